>>> hw/rtl/ucle_pkg.sv
// Package: types, codes and sizes for the circular key list engine.
package ucle_pkg;

	localparam int CAP = 256;
	localparam int SLOT_W = 8;
	localparam int CNT_W = 9;
	localparam int KEY_W = 32;

	typedef enum logic [2:0] {
		REQ_INS_HEAD  = 3'd0,
		REQ_INS_AFTER = 3'd1,
		REQ_INS_TAIL  = 3'd2,
		REQ_DEL_HEAD  = 3'd3,
		REQ_DEL_MID   = 3'd4,
		REQ_DEL_TAIL  = 3'd5,
		REQ_SEARCH    = 3'd6,
		REQ_NOP       = 3'd7
	} req_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_EMPTY     = 4'd1,
		ST_TOO_FEW   = 4'd2,
		ST_DUP       = 4'd3,
		ST_ANCHOR_NF = 4'd4,
		ST_ANCHOR_TL = 4'd5,
		ST_KEY_NF    = 4'd6,
		ST_KEY_TL    = 4'd7,
		ST_FULL      = 4'd8
	} status_t;

	typedef struct packed {
		logic [2:0]              req_type;
		logic signed [KEY_W-1:0] key;
		logic signed [KEY_W-1:0] anchor_key;
	} req_item_t;

	typedef struct packed {
		logic [3:0]       status;
		logic             found;
		logic [CNT_W-1:0] position;
		logic [CNT_W-1:0] entry_count;
	} rsp_item_t;

	typedef enum logic [3:0] {
		FS_IDLE, FS_TAIL, FS_WALK0, FS_WALK, FS_DECIDE,
		FS_ALLOC, FS_LINK1, FS_LINK2, FS_UNLINK, FS_UNLINK2, FS_DONE
	} fsm_t;

endpackage

>>> hw/rtl/unique_key_circular_list_engine_top.sv
// Top level: circular doubly linked list of unique keys in slot memories.
// Usage: drive req with start high while busy is low; that beat is taken and
// busy stays high until the single result beat, shown on rsp for one cycle
// with done high. The receiver cannot stall; a result is never held.
// Requests without a key walk (delete head or tail, unused code, refusals
// on an empty or short list, insert into an empty list) do no walk.
// A key walk reads one entry per cycle; search, middle delete and insert
// walk once, and insert-after walks twice, for the new key and then for
// the anchor. The next beat is taken in the cycle after done, when busy
// is low, so a new request is taken only once the last one is through.
// Reset clears head, count and the free stack; never-used slots are handed
// out by a fill count, so no clearing pass is needed. Key and link memories
// are undefined until written.
module unique_key_circular_list_engine_top import ucle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_item_t req,
	output logic      busy,
	output logic      done,
	output rsp_item_t rsp
);

	logic [KEY_W-1:0]  key_mem [CAP];
	logic [SLOT_W-1:0] nxt_mem [CAP];
	logic [SLOT_W-1:0] prv_mem [CAP];
	logic [SLOT_W-1:0] fre_mem [CAP];

	fsm_t state_q, state_d;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  stk_q;
	req_item_t         req_q;
	logic [SLOT_W-1:0] tail_q, cur_q, hit_q, hitnxt_q, slot_q, nb_q, pb_q;
	logic [CNT_W-1:0]  idx_q, hitpos_q;
	logic              pass_q;
	logic [3:0]        st_q, st_d;
	logic              found_q;
	logic [CNT_W-1:0]  pos_q;

	logic [KEY_W-1:0]  key_rd;
	logic [SLOT_W-1:0] nxt_rd, prv_rd, fre_rd;
	logic [SLOT_W-1:0] ra_walk, ra_prv, fre_ra;
	logic              wr_nxt, wr_prv, wr_key, wr_fre;
	logic [SLOT_W-1:0] wa_nxt, wa_prv;
	logic [SLOT_W-1:0] wd_nxt, wd_prv;
	logic [KEY_W-1:0]  tgt;
	logic              walk_hit, walk_end;
	logic [SLOT_W-1:0] new_slot;

	always_ff @(posedge clk) begin
		key_rd <= key_mem[ra_walk];
		nxt_rd <= nxt_mem[ra_walk];
		prv_rd <= prv_mem[ra_prv];
		fre_rd <= fre_mem[fre_ra];
		if (wr_key) key_mem[slot_q] <= req_q.key;
		if (wr_nxt) nxt_mem[wa_nxt] <= wd_nxt;
		if (wr_prv) prv_mem[wa_prv] <= wd_prv;
		if (wr_fre) fre_mem[stk_q[SLOT_W-1:0]] <= slot_q;
	end

	assign tgt = pass_q ? req_q.anchor_key : req_q.key;
	assign fre_ra = stk_q[SLOT_W-1:0] - 1'b1;
	assign walk_hit = key_rd == tgt;
	assign walk_end = (idx_q + 1'b1) == cnt_q;
	// recycled slot from the free stack, else the next never-used slot
	assign new_slot = (stk_q != '0) ? fre_rd : fresh_q[SLOT_W-1:0];

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		ra_walk = head_q;
		ra_prv = head_q;
		wr_key = 1'b0; wr_nxt = 1'b0; wr_prv = 1'b0; wr_fre = 1'b0;
		wa_nxt = slot_q; wa_prv = slot_q;
		wd_nxt = nb_q; wd_prv = pb_q;
		case (state_q)
			FS_IDLE: begin
				if (start) begin
					state_d = FS_TAIL;
					st_d = ST_OK;
				end
			end
			FS_TAIL: begin
				state_d = FS_DONE;
				case (req_q.req_type)
					REQ_INS_HEAD, REQ_INS_TAIL: begin
						state_d = (cnt_q == '0) ? FS_ALLOC : FS_WALK0;
					end
					REQ_INS_AFTER: begin
						if (cnt_q == '0) st_d = ST_EMPTY;
						else if (cnt_q == CNT_W'(1)) st_d = ST_TOO_FEW;
						else state_d = FS_WALK0;
					end
					REQ_DEL_HEAD, REQ_DEL_TAIL: begin
						if (cnt_q == '0) st_d = ST_EMPTY;
						else state_d = FS_UNLINK;
					end
					REQ_DEL_MID: begin
						if (cnt_q == '0) st_d = ST_EMPTY;
						else if (cnt_q < CNT_W'(3)) st_d = ST_TOO_FEW;
						else state_d = FS_WALK0;
					end
					REQ_SEARCH: begin
						if (cnt_q == '0) st_d = ST_EMPTY;
						else state_d = FS_WALK0;
					end
					default: state_d = FS_DONE;
				endcase
			end
			FS_WALK0: state_d = FS_WALK;
			FS_WALK: begin
				if (walk_hit || walk_end) state_d = FS_DECIDE;
				else ra_walk = nxt_rd;
			end
			FS_DECIDE: begin
				state_d = FS_DONE;
				case (req_q.req_type)
					REQ_INS_HEAD, REQ_INS_TAIL: begin
						if (hitpos_q != '0) st_d = ST_DUP;
						else if (cnt_q == CNT_W'(CAP)) st_d = ST_FULL;
						else state_d = FS_ALLOC;
					end
					REQ_INS_AFTER: begin
						if (!pass_q) begin
							if (hitpos_q != '0) st_d = ST_DUP;
							else state_d = FS_WALK0;
						end else if (hitpos_q == '0) st_d = ST_ANCHOR_NF;
						else if (hitpos_q == cnt_q) st_d = ST_ANCHOR_TL;
						else if (cnt_q == CNT_W'(CAP)) st_d = ST_FULL;
						else state_d = FS_ALLOC;
					end
					REQ_DEL_MID: begin
						if (hitpos_q <= CNT_W'(1)) st_d = ST_KEY_NF;
						else if (hitpos_q == cnt_q) st_d = ST_KEY_TL;
						else state_d = FS_UNLINK;
					end
					default: ;
				endcase
			end
			FS_ALLOC: state_d = FS_LINK1;
			FS_LINK1: begin
				wr_key = 1'b1;
				wr_nxt = 1'b1; wa_nxt = slot_q; wd_nxt = nb_q;
				wr_prv = 1'b1; wa_prv = slot_q; wd_prv = pb_q;
				state_d = FS_LINK2;
			end
			FS_LINK2: begin
				wr_nxt = 1'b1; wa_nxt = pb_q; wd_nxt = slot_q;
				wr_prv = 1'b1; wa_prv = nb_q; wd_prv = slot_q;
				state_d = FS_DONE;
			end
			FS_UNLINK: begin
				ra_walk = slot_q; ra_prv = slot_q;
				state_d = FS_UNLINK2;
			end
			FS_UNLINK2: begin
				wr_nxt = 1'b1; wa_nxt = prv_rd; wd_nxt = nxt_rd;
				wr_prv = 1'b1; wa_prv = nxt_rd; wd_prv = prv_rd;
				wr_fre = 1'b1;
				state_d = FS_DONE;
			end
			FS_DONE: state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FS_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			cnt_q    <= '0;
			fresh_q  <= '0;
			stk_q    <= '0;
			req_q    <= '0;
			tail_q   <= '0;
			cur_q    <= '0;
			hit_q    <= '0;
			hitnxt_q <= '0;
			slot_q   <= '0;
			nb_q     <= '0;
			pb_q     <= '0;
			idx_q    <= '0;
			hitpos_q <= '0;
			pass_q   <= 1'b0;
			st_q     <= ST_OK;
			found_q  <= 1'b0;
			pos_q    <= '0;
		end else begin
			st_q <= st_d;
			case (state_q)
				FS_IDLE: begin
					if (start) begin
						req_q <= req;
						pass_q <= 1'b0;
						found_q <= 1'b0;
						pos_q <= '0;
					end
				end
				FS_TAIL: begin
					tail_q <= prv_rd;
					slot_q <= (req_q.req_type == REQ_DEL_TAIL) ? prv_rd : head_q;
				end
				FS_WALK0: begin
					cur_q <= head_q;
					idx_q <= '0;
					hitpos_q <= '0;
				end
				FS_WALK: begin
					if (walk_hit) begin
						hitpos_q <= idx_q + 1'b1;
						hit_q <= cur_q;
						hitnxt_q <= nxt_rd;
					end else if (!walk_end) begin
						cur_q <= nxt_rd;
						idx_q <= idx_q + 1'b1;
					end
				end
				FS_DECIDE: begin
					pass_q <= 1'b1;
					slot_q <= hit_q;
					if (req_q.req_type == REQ_SEARCH) begin
						found_q <= hitpos_q != '0;
						pos_q <= hitpos_q;
					end
				end
				FS_ALLOC: begin
					slot_q <= new_slot;
					if (stk_q != '0) stk_q <= stk_q - 1'b1;
					else fresh_q <= fresh_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '0) begin
						pb_q <= new_slot;
						nb_q <= new_slot;
						head_q <= new_slot;
					end else if (req_q.req_type == REQ_INS_AFTER) begin
						pb_q <= hit_q;
						nb_q <= hitnxt_q;
					end else begin
						pb_q <= tail_q;
						nb_q <= head_q;
						if (req_q.req_type == REQ_INS_HEAD) head_q <= new_slot;
					end
				end
				FS_UNLINK2: begin
					stk_q <= stk_q + 1'b1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) head_q <= '0;
					else if (slot_q == head_q) head_q <= nxt_rd;
				end
				default: ;
			endcase
		end
	end

	assign busy = state_q != FS_IDLE;
	assign done = state_q == FS_DONE;
	assign rsp = '{status: st_q, found: found_q, position: pos_q, entry_count: cnt_q};

endmodule

>>> test/unique_key_circular_list_engine_top_test.sv
`timescale 1ns / 100ps
// Testbench: random and directed requests against a behavioral list model, results checked.
module unique_key_circular_list_engine_top_test;
	import ucle_pkg::*;

	class list_scoreboard;
		int key_list[$];
		rsp_item_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int find_pos(int k);
			foreach (key_list[i])
				if (key_list[i] == k)
					return i + 1;
			return 0;
		endfunction

		function void note_request(req_item_t r);
			rsp_item_t o;
			int n;
			int p;
			int pa;
			o = '0;
			n = key_list.size();
			case (req_t'(r.req_type))
				REQ_INS_HEAD, REQ_INS_TAIL: begin
					if (n != 0 && find_pos(r.key) != 0)
						o.status = ST_DUP;
					else if (n >= CAP)
						o.status = ST_FULL;
					else if (r.req_type == REQ_INS_HEAD)
						key_list.push_front(r.key);
					else
						key_list.push_back(r.key);
				end
				REQ_INS_AFTER: begin
					if (n == 0)
						o.status = ST_EMPTY;
					else if (n == 1)
						o.status = ST_TOO_FEW;
					else if (find_pos(r.key) != 0)
						o.status = ST_DUP;
					else begin
						pa = find_pos(r.anchor_key);
						if (pa == 0)
							o.status = ST_ANCHOR_NF;
						else if (pa == n)
							o.status = ST_ANCHOR_TL;
						else if (n >= CAP)
							o.status = ST_FULL;
						else
							key_list.insert(pa, r.key);
					end
				end
				REQ_DEL_HEAD: begin
					if (n == 0)
						o.status = ST_EMPTY;
					else
						void'(key_list.pop_front());
				end
				REQ_DEL_MID: begin
					if (n == 0)
						o.status = ST_EMPTY;
					else if (n < 3)
						o.status = ST_TOO_FEW;
					else begin
						p = find_pos(r.key);
						if (p <= 1)
							o.status = ST_KEY_NF;
						else if (p == n)
							o.status = ST_KEY_TL;
						else
							key_list.delete(p - 1);
					end
				end
				REQ_DEL_TAIL: begin
					if (n == 0)
						o.status = ST_EMPTY;
					else
						void'(key_list.pop_back());
				end
				REQ_SEARCH: begin
					if (n == 0)
						o.status = ST_EMPTY;
					else begin
						p = find_pos(r.key);
						o.found = (p != 0);
						o.position = CNT_W'(p);
					end
				end
				default: ;
			endcase
			o.entry_count = CNT_W'(key_list.size());
			pending.push_back(o);
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t exp;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected: got %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status || got.found !== exp.found ||
					got.position !== exp.position || got.entry_count !== exp.entry_count) begin
				$display({"%0t: mismatch expected st=%0d f=%0d pos=%0d cnt=%0d",
					" actual st=%0d f=%0d pos=%0d cnt=%0d"},
					$time, exp.status, exp.found, exp.position, exp.entry_count,
					got.status, got.found, got.position, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_item_t req;
	logic busy;
	logic done;
	rsp_item_t rsp;
	list_scoreboard board;
	int idle_cycles;
	bit calm;

	unique_key_circular_list_engine_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(rsp);
			if (start && !busy)
				board.note_request(req);
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("unique_key_circular_list_engine_top_test NOT OK");
				$finish;
			end
		end
	end

	task automatic send_request(req_t t, int k, int a);
		@(negedge clk);
		while (busy || (!calm && $urandom_range(99) < 6))
			@(negedge clk);
		req.req_type = t;
		req.key = k;
		req.anchor_key = a;
		start = 1'b1;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	// Pick a key: often one already held, else a small pool value or a full-range value.
	function automatic int pick_key();
		int r;
		r = $urandom_range(99);
		if (board.key_list.size() != 0 && r < 45)
			return board.key_list[$urandom_range(board.key_list.size() - 1)];
		if (r < 90)
			return int'($urandom_range(40)) - 20;
		return int'($urandom());
	endfunction

	initial begin
		int k;
		int sel;
		board = new();
		idle_cycles = 0;
		calm = 0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-list cases, extremes, every request type
		send_request(REQ_DEL_HEAD, 0, 0);
		send_request(REQ_DEL_MID, 0, 0);
		send_request(REQ_DEL_TAIL, 0, 0);
		send_request(REQ_SEARCH, 5, 0);
		send_request(REQ_INS_AFTER, 1, 2);
		send_request(REQ_INS_HEAD, 32'sh7fffffff, 0);
		send_request(REQ_INS_AFTER, 1, 32'sh7fffffff);
		send_request(REQ_INS_TAIL, 32'sh80000000, 0);
		send_request(REQ_INS_TAIL, 32'sh7fffffff, 0);
		send_request(REQ_DEL_MID, 32'sh7fffffff, 0);
		send_request(REQ_INS_AFTER, 0, 32'sh7fffffff);
		send_request(REQ_INS_AFTER, 7, 32'sh80000000);
		send_request(REQ_INS_AFTER, 7, 99);
		send_request(REQ_INS_AFTER, 0, 32'sh7fffffff);
		send_request(REQ_SEARCH, 32'sh80000000, 0);
		send_request(REQ_SEARCH, -1, 0);
		send_request(REQ_DEL_MID, 32'sh7fffffff, 0);
		send_request(REQ_DEL_MID, 32'sh80000000, 0);
		send_request(REQ_DEL_MID, 12345, 0);
		send_request(REQ_DEL_MID, 0, 0);
		send_request(REQ_NOP, -1, -1);
		send_request(REQ_DEL_HEAD, 0, 0);
		send_request(REQ_DEL_TAIL, 0, 0);
		wait_drained();

		// fill to capacity, then overflow
		for (int i = 0; i < CAP; i++)
			send_request(REQ_INS_TAIL, 1000 + i, 0);
		send_request(REQ_INS_HEAD, -5, 0);
		send_request(REQ_INS_AFTER, -5, 1000);
		send_request(REQ_INS_TAIL, 1000, 0);
		send_request(REQ_SEARCH, 1000 + CAP - 1, 0);
		for (int i = 0; i < CAP - 2; i++)
			send_request(($urandom_range(1) != 0) ? REQ_DEL_HEAD : REQ_DEL_TAIL, 0, 0);
		wait_drained();

		// random mix
		for (int i = 0; i < 620; i++) begin
			calm = (i >= 250 && i < 350);
			sel = $urandom_range(99);
			k = pick_key();
			if (board.key_list.size() > 24 && sel < 30)
				sel = 50;
			if (sel < 12)
				send_request(REQ_INS_HEAD, k, pick_key());
			else if (sel < 28)
				send_request(REQ_INS_AFTER, k, pick_key());
			else if (sel < 40)
				send_request(REQ_INS_TAIL, k, pick_key());
			else if (sel < 50)
				send_request(REQ_DEL_HEAD, k, pick_key());
			else if (sel < 68)
				send_request(REQ_DEL_MID, k, pick_key());
			else if (sel < 76)
				send_request(REQ_DEL_TAIL, k, pick_key());
			else if (sel < 97)
				send_request(REQ_SEARCH, k, pick_key());
			else
				send_request(REQ_NOP, int'($urandom()), int'($urandom()));
			if (i == 400)
				wait_drained();
		end
		calm = 0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("unique_key_circular_list_engine_top_test OK");
		else
			$display("unique_key_circular_list_engine_top_test NOT OK");
		$finish;
	end
endmodule
